>>> design/lcm_pkg.sv
// Package for the linear congruence merge block.
// Holds field widths, status codes and the divider request struct; no dependencies.
`timescale 1ns / 1ps
package lcm_pkg;
  localparam int MW = 32;
  localparam int AW = 64;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSOL   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic        start;
    logic [AW-1:0] num;
    logic [AW-1:0] den;
  } div_req_t;
endpackage

>>> design/lcm_div.sv
// Bit-serial unsigned divider, one quotient bit per cycle.
// Depends on lcm_pkg for widths and the request struct.
`timescale 1ns / 1ps
module lcm_div import lcm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  div_req_t        req,
  output logic            done,
  output logic [AW-1:0]   quo,
  output logic [AW-1:0]   rem
);
  logic [AW-1:0] den;
  logic [AW-1:0] r;
  logic [AW-1:0] q;
  logic [6:0]    cnt;
  logic          busy;
  logic [AW:0]   sh;
  logic          ge;

  assign sh = {r, q[AW-1]};
  assign ge = sh >= {1'b0, den};
  assign quo = q;
  assign rem = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        den  <= req.den;
        q    <= req.num;
        r    <= '0;
        cnt  <= 7'(AW);
      end else if (busy) begin
        r   <= ge ? AW'(sh - {1'b0, den}) : sh[AW-1:0];
        q   <= {q[AW-2:0], ge};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> design/lcm_mul.sv
// Shift-add modular multiplier: (x * y) mod n, one bit of y per cycle.
// Depends on lcm_pkg; inputs x below n are assumed.
`timescale 1ns / 1ps
module lcm_mul import lcm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] x,
  input  logic [AW-1:0] y,
  input  logic [AW-1:0] n,
  output logic          done,
  output logic [AW-1:0] p
);
  logic [AW-1:0] yy, nn, xx;
  logic [6:0]    cnt;
  logic          busy;
  logic [AW:0]   d2, s;
  logic [AW-1:0] d2r;
  logic [AW-1:0] dbl;

  // MSB-first: acc = 2*acc (+ x)
  assign d2  = {p, 1'b0};
  assign dbl = (d2 >= {1'b0, nn}) ? AW'(d2 - {1'b0, nn}) : p << 1;
  assign s   = {1'b0, dbl} + {1'b0, xx};
  assign d2r = (s >= {1'b0, nn}) ? AW'(s - {1'b0, nn}) : s[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        xx <= x; yy <= y; nn <= n; p <= '0;
        cnt <= 7'(AW);
      end else if (busy) begin
        p   <= yy[AW-1] ? d2r : dbl;
        yy  <= yy << 1;
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> design/linear_congruence_merge.sv
// Top level of the linear congruence merge block.
// Depends on lcm_pkg, lcm_div and lcm_mul.
//
// Usage: each input beat carries one congruence coefficient*x = residue
// (mod modulus) and a start_system flag that clears the running system first.
// Exactly one output beat follows each input beat, giving the running
// solution, combined modulus and status (consistent, no solution, overflow).
// Failures stick until the next start_system beat; a failed result shows
// solution 0 and combined modulus 1.
// Work: one item runs a chain of bit-serial divides and modular
// multiplies on one shared divider and one shared multiplier. A checked item
// takes 7 to 15 of them plus the Euclid loops: one divide per gcd step, two
// divides and a multiply per inverse step, at most 46 steps each for 32-bit
// moduli. A beat ignored after a failure gives its result in the cycle
// after acceptance. One item is worked at a time; the next input beat
// is taken in the cycle after the result beat leaves.
// in_stall is high whenever an item is in work or its result is unread.
// Reset clears the running system to solution 0, modulus 1, consistent.
// When the receiver stalls, the result beat holds until taken.
`timescale 1ns / 1ps
module linear_congruence_merge import lcm_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            start_system,
  input  logic [MW-1:0]   coefficient,
  input  logic [MW-1:0]   residue,
  input  logic [MW-1:0]   modulus,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [AW-1:0]   solution,
  output logic [AW-1:0]   combined_modulus,
  output logic [1:0]      status
);
  typedef enum logic [20:0] {
    S_IDLE = 21'd1,      S_AR   = 21'd2,      S_RM   = 21'd4,
    S_COEF = 21'd8,      S_RS   = 21'd16,     S_ARS  = 21'd32,
    S_BM   = 21'd64,     S_G    = 21'd128,    S_RD   = 21'd256,
    S_SMOD = 21'd512,    S_CD   = 21'd1024,   S_EQ   = 21'd2048,
    S_EM   = 21'd4096,   S_RHD  = 21'd8192,   S_RHM  = 21'd16384,
    S_T    = 21'd32768,  S_OV   = 21'd65536,  S_UPD  = 21'd131072,
    S_UMUL = 21'd262144, S_OUT  = 21'd524288, S_MOD  = 21'd1048576
  } state_t;

  state_t        st;
  logic [AW-1:0] rsol, rmod;
  status_t       fail;
  logic [AW-1:0] b, mi, ar, coef, rhs, tmp, d, smod, inv, t;
  logic [AW-1:0] r0, r1, s0, s1;
  logic          wait_u;

  div_req_t      dreq;
  logic          ddone;
  logic [AW-1:0] dquo, drem;
  logic          mstart, mdone;
  logic [AW-1:0] mx, my, mn, mp;

  lcm_div u_div (.clk, .rst, .req(dreq), .done(ddone), .quo(dquo), .rem(drem));
  lcm_mul u_mul (.clk, .rst, .start(mstart), .x(mx), .y(my), .n(mn), .done(mdone),
                 .p(mp));

  assign in_stall = (st != S_IDLE);
  assign out_valid = (st == S_OUT);

  logic [AW:0]   rsum;
  logic [AW-1:0] rdiff;
  assign rsum  = {1'b0, s0} + {1'b0, smod} - {1'b0, mp};
  assign rdiff = (rsum >= {1'b0, smod}) ? AW'(rsum - {1'b0, smod}) : rsum[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; rsol <= '0; rmod <= AW'(1); fail <= ST_OK;
      dreq <= '0; mstart <= 1'b0; wait_u <= 1'b0;
    end else begin
      dreq.start <= 1'b0;
      mstart <= 1'b0;
      unique case (st)
        S_IDLE: if (in_valid) begin
          b  <= AW'(residue);
          mi <= (modulus == '0) ? AW'(1) : AW'(modulus);
          if (start_system) begin
            rsol <= '0; rmod <= AW'(1); fail <= ST_OK;
          end
          if (start_system || fail == ST_OK) begin
            dreq <= '{1'b1, AW'(coefficient),
                      (modulus == '0) ? AW'(1) : AW'(modulus)};
            wait_u <= 1'b1;
            st <= S_AR;
          end else st <= S_OUT;
        end
        S_AR: if (ddone) begin
          ar <= drem;
          dreq <= '{1'b1, rmod, mi};
          st <= S_RM;
        end
        S_RM: if (ddone) begin
          mstart <= 1'b1; mx <= ar; my <= drem; mn <= mi;
          st <= S_COEF;
        end
        S_COEF: if (mdone) begin
          coef <= mp;
          dreq <= '{1'b1, rsol, mi};
          st <= S_RS;
        end
        S_RS: if (ddone) begin
          mstart <= 1'b1; mx <= ar; my <= drem; mn <= mi;
          st <= S_ARS;
        end
        S_ARS: if (mdone) begin
          tmp <= mp;
          dreq <= '{1'b1, b, mi};
          st <= S_BM;
        end
        S_BM: if (ddone) begin
          rhs <= (drem >= tmp) ? drem - tmp : drem + mi - tmp;
          r0 <= mi; r1 <= coef;
          st <= S_G;
        end
        S_G: begin
          if (wait_u) begin
            if (r1 == '0) begin
              d <= r0;
              dreq <= '{1'b1, rhs, r0};
              st <= S_RD;
            end else begin
              dreq <= '{1'b1, r0, r1};
              wait_u <= 1'b0;
            end
          end else if (ddone) begin
            r0 <= r1; r1 <= drem; wait_u <= 1'b1;
          end
        end
        S_RD: if (ddone) begin
          if (drem != '0) begin
            fail <= ST_NOSOL; st <= S_OUT;
          end else begin
            tmp <= dquo;
            dreq <= '{1'b1, mi, d};
            st <= S_SMOD;
          end
        end
        S_SMOD: if (ddone) begin
          smod <= dquo;
          if (dquo <= AW'(1)) begin
            t <= '0;
            dreq <= '{1'b1, {AW{1'b1}}, dquo};
            st <= S_OV;
          end else begin
            dreq <= '{1'b1, coef, d};
            st <= S_CD;
          end
        end
        S_CD: if (ddone) begin
          dreq <= '{1'b1, dquo, smod};
          st <= S_EM;
          wait_u <= 1'b1;
        end
        S_EM: if (ddone) begin
          r0 <= smod; r1 <= drem; s0 <= '0; s1 <= AW'(1);
          wait_u <= 1'b1;
          st <= S_EQ;
        end
        S_EQ: begin
          if (wait_u) begin
            if (r1 == '0) begin
              inv <= s0;
              dreq <= '{1'b1, tmp, smod};
              st <= S_RHD;
            end else begin
              dreq <= '{1'b1, r0, r1};
              wait_u <= 1'b0;
            end
          end else if (ddone) begin
            r0 <= r1; r1 <= drem;
            dreq <= '{1'b1, dquo, smod};
            st <= S_RHM;
          end
        end
        S_RHM: if (ddone) begin
          mstart <= 1'b1; mx <= drem; my <= s1; mn <= smod;
          st <= S_UMUL;
        end
        S_UMUL: if (mdone) begin
          s0 <= s1; s1 <= rdiff; wait_u <= 1'b1;
          st <= S_EQ;
        end
        S_RHD: if (ddone) begin
          mstart <= 1'b1; mx <= drem; my <= inv; mn <= smod;
          st <= S_T;
        end
        S_T: if (mdone) begin
          t <= mp;
          dreq <= '{1'b1, {AW{1'b1}}, smod};
          st <= S_OV;
        end
        S_OV: if (ddone) begin
          if (rmod > dquo) begin
            fail <= ST_OVERFLOW; st <= S_OUT;
          end else begin
            mstart <= 1'b1; mx <= t; my <= rmod; mn <= '0;
            st <= S_UPD;
          end
        end
        S_UPD: if (mdone) begin
          rsol <= rsol + mp;
          mstart <= 1'b1; mx <= smod; my <= rmod; mn <= '0;
          st <= S_MOD;
        end
        S_MOD: if (mdone) begin
          rmod <= mp;
          st <= S_OUT;
        end
        S_OUT: if (!out_stall) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  assign solution         = (fail == ST_OK) ? rsol : '0;
  assign combined_modulus = (fail == ST_OK) ? rmod : AW'(1);
  assign status           = fail;
endmodule

>>> bench/tb_top.sv
// Self-checking bench for linear_congruence_merge: directed and random congruence systems.
// Depends on lcm_pkg and the linear_congruence_merge RTL; predicts results with its own CRT merge.
`timescale 1ns / 1ps
module tb_top import lcm_pkg::*;;

  typedef struct {
    bit        start;
    bit [31:0] coef;
    bit [31:0] res;
    bit [31:0] md;
  } congruence_t;

  typedef struct {
    bit [63:0] sol;
    bit [63:0] cmod;
    status_t   st;
  } merge_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic start_system = 1'b0;
  logic [MW-1:0] coefficient = '0;
  logic [MW-1:0] residue = '0;
  logic [MW-1:0] modulus = 32'd1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AW-1:0] solution;
  logic [AW-1:0] combined_modulus;
  logic [1:0] status;

  congruence_t pending_beats[$];
  merge_result_t expected_results[$];
  congruence_t cur_beat;
  bit [63:0] sys_sol = 0;
  bit [63:0] sys_mod = 1;
  status_t sys_fail = ST_OK;
  int sent = 0;
  int accepted = 0;
  int errors = 0;
  int holdoff = 0;
  bit holdoff_done = 0;
  longint cycles = 0;

  linear_congruence_merge uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit [63:0] gcd64(bit [63:0] p, bit [63:0] q);
    bit [63:0] r;
    while (q != 0) begin
      r = p % q;
      p = q;
      q = r;
    end
    return p;
  endfunction

  function automatic bit [63:0] inv_mod64(bit [63:0] u, bit [63:0] n);
    bit [63:0] r0, r1, s0, s1, q, nr, ns;
    if (n <= 1) return 0;
    r0 = n;
    r1 = u % n;
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      q = r0 / r1;
      nr = r0 - q * r1;
      ns = (s0 + n - (q * s1) % n) % n;
      r0 = r1;
      r1 = nr;
      s0 = s1;
      s1 = ns;
    end
    return s0 % n;
  endfunction

  function automatic merge_result_t merge_congruence(congruence_t c);
    bit [63:0] a, b, mi, ar, cf, rhs, d, step, t;
    merge_result_t r;
    a = c.coef;
    b = c.res;
    mi = c.md;
    if (c.start) begin
      sys_sol = 0;
      sys_mod = 1;
      sys_fail = ST_OK;
    end
    if (mi == 0) mi = 1;
    if (sys_fail == ST_OK) begin
      ar = a % mi;
      cf = (ar * (sys_mod % mi)) % mi;
      rhs = (b % mi + mi - (ar * (sys_sol % mi)) % mi) % mi;
      d = gcd64(mi, cf);
      if (rhs % d != 0) begin
        sys_fail = ST_NOSOL;
      end else begin
        step = mi / d;
        t = 0;
        if (step > 1) t = ((rhs / d) % step * inv_mod64(cf / d, step)) % step;
        if (sys_mod > 64'hFFFF_FFFF_FFFF_FFFF / step) begin
          sys_fail = ST_OVERFLOW;
        end else begin
          sys_sol = sys_sol + sys_mod * t;
          sys_mod = sys_mod * step;
        end
      end
    end
    r.sol = (sys_fail == ST_OK) ? sys_sol : 64'd0;
    r.cmod = (sys_fail == ST_OK) ? sys_mod : 64'd1;
    r.st = sys_fail;
    return r;
  endfunction

  function automatic void push_beat(bit s, bit [31:0] a, bit [31:0] b, bit [31:0] m);
    congruence_t c;
    c.start = s;
    c.coef = a;
    c.res = b;
    c.md = m;
    pending_beats.push_back(c);
  endfunction

  function automatic bit [31:0] rand_modulus();
    int k;
    k = $urandom_range(99);
    if (k < 3) return 0;
    if (k < 60) return $urandom_range(1, 60);
    if (k < 85) return $urandom_range(1, 100000);
    return $urandom;
  endfunction

  function automatic void push_system();
    bit [63:0] x;
    bit [31:0] a, m, b;
    int len;
    x = {$urandom, $urandom};
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      m = rand_modulus();
      a = ($urandom_range(1)) ? $urandom : $urandom_range(0, 20);
      if (m == 0) b = $urandom;
      else b = 32'((64'(a) * (x % m)) % m);
      if ($urandom_range(99) < 8) b = $urandom;
      push_beat(i == 0, a, b, m);
    end
  endfunction

  function automatic int sender_idle_pct(int n);
    case ((n / 250) % 4)
      1: return 68;
      3: return 10;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int n);
    case ((n / 250) % 4)
      2: return 68;
      3: return 10;
      default: return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(merge_congruence(cur_beat));
        accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= sender_idle_pct(sent)) begin
          cur_beat = pending_beats.pop_front();
          sent++;
          in_valid <= 1'b1;
          start_system <= cur_beat.start;
          coefficient <= cur_beat.coef;
          residue <= cur_beat.res;
          modulus <= cur_beat.md;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // hold off the output once for a long stretch while beats keep coming
  always @(posedge clk) begin
    if (!rst && !holdoff_done && accepted == 100) begin
      holdoff <= 20000;
      holdoff_done <= 1'b1;
    end else if (holdoff > 0) begin
      holdoff <= holdoff - 1;
    end
  end

  always @(posedge clk) begin
    merge_result_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= (holdoff > 1) || ($urandom_range(99) < receiver_stall_pct(accepted));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: solution %0d status %0d", solution, status);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (solution !== e.sol) begin
            $error("solution: expected %0d actual %0d", e.sol, solution);
            errors++;
          end
          if (combined_modulus !== e.cmod) begin
            $error("combined_modulus: expected %0d actual %0d", e.cmod, combined_modulus);
            errors++;
          end
          if (status !== e.st) begin
            $error("status: expected %0d actual %0d", e.st, status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd150_000_000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    // extremes, zero modulus, wide operands
    push_beat(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_beat(0, 32'd0, 32'd0, 32'd0);
    push_beat(1, 32'd0, 32'd5, 32'd7);
    push_beat(1, 32'd0, 32'd0, 32'd1);
    push_beat(1, 32'd3, 32'd2, 32'd5);
    push_beat(0, 32'd1, 32'd3, 32'd7);
    push_beat(0, 32'd2, 32'd4, 32'd6);
    // no solution, then sticky ignore, then restart
    push_beat(0, 32'd1, 32'd1, 32'd2);
    push_beat(0, 32'd1, 32'd0, 32'd3);
    push_beat(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_beat(1, 32'd6, 32'd4, 32'd10);
    // overflow of the combined modulus, sticky, restart
    push_beat(1, 32'd1, 32'd12345, 32'hFFFF_FFFB);
    push_beat(0, 32'd1, 32'd999, 32'hFFFF_FFFF);
    push_beat(0, 32'd1, 32'd7, 32'hFFFF_FFF1);
    push_beat(0, 32'd1, 32'd7, 32'd13);
    push_beat(1, 32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000);
    push_beat(0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
    push_beat(1, 32'd4, 32'd2, 32'd8);
    while (pending_beats.size() < 1950) begin
      if ($urandom_range(99) < 85) push_system();
      else push_beat($urandom_range(1), $urandom, $urandom, rand_modulus());
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_beats.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
